// File: sv/vglp_pkg.sv
// package for the variant line genotype parser
// result item layout, status codes and character constants; no dependencies

package vglp_pkg;

  // samples a line may carry at most, whatever the register says
  localparam int unsigned MAX_SAMPLES = 4096;
  // result queue depth between the parser and the output channel
  localparam int unsigned QUEUE_DEPTH = 3;

  localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;
  localparam logic [13:0] CNT_MAX = 14'd16383;

  // result kinds
  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // line status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BAD_GT  = 3'd2;
  localparam logic [2:0] ST_FORMAT  = 3'd3;
  localparam logic [2:0] ST_EXCESS  = 3'd4;
  localparam logic [2:0] ST_NO_POS  = 3'd5;

  // columns of interest
  localparam logic [3:0] COL_POS    = 4'd1;
  localparam logic [3:0] COL_FORMAT = 4'd8;
  localparam logic [3:0] COL_SAMPLE = 4'd9;

  // position field progress
  localparam logic [1:0] POS_SIGN   = 2'd0;
  localparam logic [1:0] POS_DIGITS = 2'd1;
  localparam logic [1:0] POS_DONE   = 2'd2;

  // format field progress
  localparam logic [1:0] FMT_START = 2'd0;
  localparam logic [1:0] FMT_G     = 2'd1;
  localparam logic [1:0] FMT_GT    = 2'd2;
  localparam logic [1:0] FMT_BAD   = 2'd3;

  // genotype field progress
  localparam logic [1:0] GT_NONE   = 2'd0;
  localparam logic [1:0] GT_FIRST  = 2'd1;
  localparam logic [1:0] GT_BAR    = 2'd2;
  localparam logic [1:0] GT_SECOND = 2'd3;

  // characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  typedef struct packed {
    logic        kind;
    logic [11:0] sample_index;
    logic        left_hap;
    logic        right_hap;
    logic [2:0]  status;
    logic [30:0] position;
    logic [13:0] minor_count;
    logic        last;
  } result_t;

endpackage

// File: sv/vglp_parse.sv
// per-line parse state and per-byte update for the variant line parser
// holds the sample limit register; depends on vglp_pkg

module vglp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       text_byte,
  input  logic             end_of_line,
  input  logic             cfg_we,
  input  logic [12:0]      cfg_wdata,
  output logic [1:0]       res_count,
  output vglp_pkg::result_t res_first,
  output vglp_pkg::result_t res_second
);
  import vglp_pkg::*;

  logic [12:0] num_samples;

  logic [3:0]  column_number, column_number_next;
  logic        inside_field, inside_field_next;
  logic        line_fresh, line_fresh_next;
  logic [30:0] position_value, position_value_next;
  logic [1:0]  position_phase, position_phase_next;
  logic        position_negative, position_negative_next;
  logic        position_seen, position_seen_next;
  logic [1:0]  format_progress, format_progress_next;
  logic [1:0]  genotype_phase, genotype_phase_next;
  logic [7:0]  held_first_char, held_first_char_next;
  logic [7:0]  held_second_char, held_second_char_next;
  logic [13:0] ones_total, ones_total_next;
  logic [13:0] zeros_total, zeros_total_next;
  logic [12:0] sample_counter, sample_counter_next;
  logic [2:0]  line_status, line_status_next;

  // field close results
  logic [7:0]  hap_a, hap_b;
  logic        a_ok, b_ok, over_limit;
  logic [1:0]  add_ones, add_zeros;
  logic [31:0] limit;
  logic        close_pair;
  logic [2:0]  close_status;
  logic [13:0] close_ones, close_zeros;
  logic [12:0] close_samples;
  logic [3:0]  close_column;
  result_t     close_result;

  // summary and byte path helpers
  logic [2:0]  sum_status, status_now;
  logic [13:0] sum_ones, sum_zeros;
  result_t     summary;
  logic [7:0]  digit;
  logic [34:0] pos_scaled;

  function automatic logic [13:0] sat_count(input logic [13:0] v, input logic [1:0] add);
    logic [14:0] s;
    s = {1'b0, v} + {13'b0, add};
    if (s > {1'b0, CNT_MAX}) begin
      return CNT_MAX;
    end
    return s[13:0];
  endfunction

  always_comb begin
    hap_a = held_first_char;
    case (genotype_phase)
      GT_FIRST: hap_b = held_first_char;
      GT_BAR:   hap_b = 8'h00;
      default:  hap_b = held_second_char;
    endcase
    a_ok      = (hap_a == CH_ZERO) || (hap_a == CH_ONE);
    b_ok      = (hap_b == CH_ZERO) || (hap_b == CH_ONE);
    add_ones  = {1'b0, hap_a == CH_ONE} + {1'b0, hap_b == CH_ONE};
    add_zeros = {1'b0, hap_a == CH_ZERO} + {1'b0, hap_b == CH_ZERO};
    limit      = (32'(num_samples) < MAX_SAMPLES) ? 32'(num_samples) : MAX_SAMPLES;
    over_limit = 32'(sample_counter) >= limit;

    close_pair    = 1'b0;
    close_status  = line_status;
    close_ones    = ones_total;
    close_zeros   = zeros_total;
    close_samples = sample_counter;
    if (line_status == ST_OK) begin
      if (column_number == COL_FORMAT && format_progress != FMT_GT) begin
        close_status = ST_FORMAT;
      end else if (column_number >= COL_SAMPLE) begin
        if (!(a_ok && b_ok)) begin
          close_status = ST_BAD_GT;
        end else if (over_limit) begin
          close_status = ST_EXCESS;
        end else begin
          close_pair    = 1'b1;
          close_ones    = sat_count(ones_total, add_ones);
          close_zeros   = sat_count(zeros_total, add_zeros);
          close_samples = sample_counter + 13'd1;
        end
      end
    end
    close_column = (column_number < COL_SAMPLE) ? column_number + 4'd1 : column_number;

    close_result              = '0;
    close_result.kind         = KIND_PAIR;
    close_result.sample_index = sample_counter[11:0];
    close_result.left_hap     = (hap_a == CH_ONE);
    close_result.right_hap    = (hap_b == CH_ONE);
  end

  always_comb begin
    column_number_next     = column_number;
    inside_field_next      = inside_field;
    line_fresh_next        = line_fresh;
    position_value_next    = position_value;
    position_phase_next    = position_phase;
    position_negative_next = position_negative;
    position_seen_next     = position_seen;
    format_progress_next   = format_progress;
    genotype_phase_next    = genotype_phase;
    held_first_char_next   = held_first_char;
    held_second_char_next  = held_second_char;
    ones_total_next        = ones_total;
    zeros_total_next       = zeros_total;
    sample_counter_next    = sample_counter;
    line_status_next       = line_status;
    res_count  = 2'd0;
    res_first  = '0;
    res_second = '0;
    sum_status = line_status;
    sum_ones   = ones_total;
    sum_zeros  = zeros_total;
    summary    = '0;
    status_now = line_status;
    digit      = text_byte - CH_ZERO;
    pos_scaled = '0;

    if (end_of_line) begin
      if (line_fresh) begin
        sum_status = ST_EMPTY;
      end else if (inside_field) begin
        sum_status = close_status;
        sum_ones   = close_ones;
        sum_zeros  = close_zeros;
        if (close_pair) begin
          res_first = close_result;
          res_count = 2'd1;
        end
      end
      if (sum_status == ST_OK &&
          (!position_seen || (position_negative && position_value != '0))) begin
        sum_status = ST_NO_POS;
      end
      summary.kind   = KIND_SUMMARY;
      summary.status = sum_status;
      summary.last   = 1'b1;
      if (sum_status == ST_OK) begin
        summary.position    = position_value;
        summary.minor_count = (sum_ones > sum_zeros) ? sum_zeros : sum_ones;
      end
      if (res_count == 2'd0) begin
        res_first = summary;
      end else begin
        res_second = summary;
      end
      res_count = res_count + 2'd1;

      // back to the start-of-line state
      column_number_next     = '0;
      inside_field_next      = 1'b0;
      line_fresh_next        = 1'b1;
      position_value_next    = '0;
      position_phase_next    = POS_SIGN;
      position_negative_next = 1'b0;
      position_seen_next     = 1'b0;
      format_progress_next   = FMT_START;
      genotype_phase_next    = GT_NONE;
      held_first_char_next   = '0;
      held_second_char_next  = '0;
      ones_total_next        = '0;
      zeros_total_next       = '0;
      sample_counter_next    = '0;
      line_status_next       = ST_OK;
    end else begin
      if (line_fresh) begin
        line_fresh_next = 1'b0;
        if (num_samples != '0 && text_byte == CH_HASH) begin
          status_now = ST_EMPTY;
        end
      end
      line_status_next = status_now;
      if (status_now == ST_OK) begin
        if (text_byte == CH_TAB) begin
          if (inside_field) begin
            line_status_next    = close_status;
            ones_total_next     = close_ones;
            zeros_total_next    = close_zeros;
            sample_counter_next = close_samples;
            column_number_next  = close_column;
            inside_field_next   = 1'b0;
            if (close_pair) begin
              res_first      = close_result;
              res_first.last = 1'b1;
              res_count      = 2'd1;
            end
          end
        end else begin
          if (!inside_field) begin
            inside_field_next     = 1'b1;
            format_progress_next  = FMT_START;
            genotype_phase_next   = GT_NONE;
            held_first_char_next  = '0;
            held_second_char_next = '0;
            if (column_number == COL_POS) begin
              position_seen_next     = 1'b1;
              position_phase_next    = POS_SIGN;
              position_negative_next = 1'b0;
              position_value_next    = '0;
            end
          end
          pos_scaled = ({4'b0, position_value_next} << 3) +
                       ({4'b0, position_value_next} << 1) + {27'b0, digit};
          if (column_number == COL_POS) begin
            if (position_phase_next == POS_SIGN &&
                (text_byte == CH_SPACE || (text_byte >= CH_LF && text_byte <= CH_CR))) begin
              // leading white space is skipped
            end else if (position_phase_next == POS_SIGN &&
                         (text_byte == CH_PLUS || text_byte == CH_MINUS)) begin
              position_negative_next = (text_byte == CH_MINUS);
              position_phase_next    = POS_DIGITS;
            end else if (position_phase_next != POS_DONE && digit <= 8'd9) begin
              position_phase_next = POS_DIGITS;
              position_value_next = (pos_scaled > {4'b0, POS_MAX}) ? POS_MAX
                                                                   : pos_scaled[30:0];
            end else begin
              position_phase_next = POS_DONE;
            end
          end else if (column_number == COL_FORMAT) begin
            if (format_progress_next == FMT_START && text_byte == CH_G) begin
              format_progress_next = FMT_G;
            end else if (format_progress_next == FMT_G && text_byte == CH_T) begin
              format_progress_next = FMT_GT;
            end else begin
              format_progress_next = FMT_BAD;
            end
          end else if (column_number >= COL_SAMPLE) begin
            case (genotype_phase_next)
              GT_NONE: begin
                if (text_byte == CH_BAR) begin
                  held_first_char_next = '0;
                  genotype_phase_next  = GT_BAR;
                end else begin
                  held_first_char_next = text_byte;
                  genotype_phase_next  = GT_FIRST;
                end
              end
              GT_FIRST: begin
                if (text_byte == CH_BAR) begin
                  genotype_phase_next = GT_BAR;
                end
              end
              GT_BAR: begin
                held_second_char_next = text_byte;
                genotype_phase_next   = GT_SECOND;
              end
              default: begin
                // characters after the second allele are ignored
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= '0;
    end else if (cfg_we) begin
      num_samples <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_number     <= '0;
      inside_field      <= 1'b0;
      line_fresh        <= 1'b1;
      position_value    <= '0;
      position_phase    <= POS_SIGN;
      position_negative <= 1'b0;
      position_seen     <= 1'b0;
      format_progress   <= FMT_START;
      genotype_phase    <= GT_NONE;
      held_first_char   <= '0;
      held_second_char  <= '0;
      ones_total        <= '0;
      zeros_total       <= '0;
      sample_counter    <= '0;
      line_status       <= ST_OK;
    end else if (take) begin
      column_number     <= column_number_next;
      inside_field      <= inside_field_next;
      line_fresh        <= line_fresh_next;
      position_value    <= position_value_next;
      position_phase    <= position_phase_next;
      position_negative <= position_negative_next;
      position_seen     <= position_seen_next;
      format_progress   <= format_progress_next;
      genotype_phase    <= genotype_phase_next;
      held_first_char   <= held_first_char_next;
      held_second_char  <= held_second_char_next;
      ones_total        <= ones_total_next;
      zeros_total       <= zeros_total_next;
      sample_counter    <= sample_counter_next;
      line_status       <= line_status_next;
    end
  end

endmodule

// File: sv/vcf_genotype_line_parser_core.sv
// Phased genotype line parser, top level.
// Byte channel: byte_valid / byte_stall carry text_byte and end_of_line, one
// character per item; an item with end_of_line set closes the line.
// Result channel: result_valid / result_stall carry one result per item:
// a haplotype pair per sample column (kind 0) and, at each end of line, a
// summary (kind 1) with status, position and minor allele count. last marks
// the final result caused by one byte item.
// cfg_we / cfg_wdata write the sample limit; write it only while idle.
// Throughput: one byte item per cycle unless byte_stall is high. Each item
// is parsed in the cycle it is accepted and its results land in a three-entry
// result queue, so a result is registered before it is offered. An end of line
// that closes a sample column gives two results, which drain at one per cycle
// unless result_stall is high; the queue is what sets the occasional one-cycle
// stall on the byte channel. When the receiver stalls, the queue fills and
// byte_stall rises once fewer than two entries are free. Synchronous reset
// empties the queue, clears the line state and sets the sample limit to zero.
// Depends on vglp_pkg and vglp_parse.

module vcf_genotype_line_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_line,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [11:0] sample_index,
  output logic        left_hap,
  output logic        right_hap,
  output logic [2:0]  status,
  output logic [30:0] position,
  output logic [13:0] minor_count,
  output logic        last
);
  import vglp_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             take, pop;
  logic [1:0]       res_count;
  logic [1:0]       push_count;
  result_t          res_first, res_second;
  result_t          slot [QUEUE_DEPTH];
  result_t          slot_next [QUEUE_DEPTH];
  logic [CNT_W-1:0] fill, fill_next, base;

  assign byte_stall   = fill > CNT_W'(QUEUE_DEPTH - 2);
  assign take         = byte_valid && !byte_stall;
  assign result_valid = fill != '0;
  assign pop          = result_valid && !result_stall;
  assign push_count   = take ? res_count : 2'd0;
  assign base         = fill - CNT_W'(pop);
  assign fill_next    = base + CNT_W'(push_count);

  vglp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_byte   (text_byte),
    .end_of_line (end_of_line),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .res_count   (res_count),
    .res_first   (res_first),
    .res_second  (res_second)
  );

  // shifting queue: entries move down on a pop, new items join at the tail
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    always_comb begin
      if (i < QUEUE_DEPTH - 1) begin
        slot_next[i] = pop ? slot[(i + 1) % QUEUE_DEPTH] : slot[i];
      end else begin
        slot_next[i] = slot[i];
      end
      if (push_count != 2'd0 && base == CNT_W'(i)) begin
        slot_next[i] = res_first;
      end
      if (push_count == 2'd2 && CNT_W'(base + CNT_W'(1)) == CNT_W'(i)) begin
        slot_next[i] = res_second;
      end
    end

    always_ff @(posedge clk) begin
      slot[i] <= slot_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  assign kind         = slot[0].kind;
  assign sample_index = slot[0].sample_index;
  assign left_hap     = slot[0].left_hap;
  assign right_hap    = slot[0].right_hap;
  assign status       = slot[0].status;
  assign position     = slot[0].position;
  assign minor_count  = slot[0].minor_count;
  assign last         = slot[0].last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_pair_then_summary: assert property (@(posedge clk) disable iff (rst)
    push_count == 2'd2 |-> res_first.kind == KIND_PAIR && !res_first.last &&
                           res_second.kind == KIND_SUMMARY && res_second.last)
    else $error("two results from one item out of order");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_SUMMARY |-> last)
    else $error("line summary without last");

  a_pair_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_PAIR |-> status == ST_OK && position == '0 &&
                                          minor_count == '0)
    else $error("pair item carries summary fields");

endmodule
